// File: src/smh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the shingle minhash signature block
// no dependencies

package smh_pkg;

  localparam int unsigned MaxHashes = 3;
  localparam int unsigned HashW     = 32;
  localparam int unsigned SigW      = 31;
  localparam int unsigned SymW      = 8;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [SigW-1:0]  MinStart = {SigW{1'b1}};

  localparam logic [HashW-1:0] SeedZeroRst  = 32'd59;
  localparam logic [HashW-1:0] SeedOneRst   = 32'd81;
  localparam logic [HashW-1:0] SeedTwoRst   = 32'd83;
  localparam logic [HashW-1:0] ChainMultRst = 32'd7;
  localparam logic [HashW-1:0] MultZeroRst  = 32'd13;
  localparam logic [HashW-1:0] MultOneRst   = 32'd17;
  localparam logic [HashW-1:0] MultTwoRst   = 32'd27;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeedZero  = 3'd0,
    CfgSeedOne   = 3'd1,
    CfgSeedTwo   = 3'd2,
    CfgChainMult = 3'd3,
    CfgMultZero  = 3'd4,
    CfgMultOne   = 3'd5,
    CfgMultTwo   = 3'd6
  } cfg_idx_e;

  // per-cycle control shared by all hash lanes
  typedef struct packed {
    logic a_load;     // input transaction accepted
    logic sym_vld;    // item carries a character
    logic started;    // open token already has a character
    logic close;      // token closes with this item
    logic b_adv;      // minimum stage consumes its entry
    logic b_cand;     // minimum stage entry holds a shingle hash
    logic b_row_end;  // minimum stage entry ends the row
  } ctl_t;

endpackage

// File: src/smh_lane.sv
`timescale 1ns / 1ps
// one hash function lane: token and shingle hash update, then running minimum
// depends on smh_pkg

module smh_lane
  import smh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  input  logic [SymW-1:0]  symbol_i,
  input  logic [HashW-1:0] seed_i,
  input  logic [HashW-1:0] chain_i,
  input  logic [HashW-1:0] mult_i,
  output logic [SigW-1:0]  min_next_o
);

  logic [HashW-1:0] cur_q, prev_q, sh_q, cand_q;
  logic [SigW-1:0]  min_q;

  logic [HashW-1:0] cur_base, sh_base, sym_term, cur_mix, sh_mix, cur_upd, sh_upd;
  logic             cand_lt;

  assign cur_base = ctl_i.started ? cur_q : seed_i;
  assign sh_base  = ctl_i.started ? sh_q : prev_q;
  assign sym_term = HashW'(mult_i * {{(HashW-SymW){1'b0}}, symbol_i});
  assign cur_mix  = HashW'(cur_base * chain_i) ^ sym_term;
  assign sh_mix   = HashW'(sh_base * chain_i) ^ sym_term;
  assign cur_upd  = ctl_i.sym_vld ? cur_mix : cur_q;
  assign sh_upd   = ctl_i.sym_vld ? sh_mix : sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      prev_q <= '0;
      sh_q   <= '0;
      cand_q <= '0;
    end else if (ctl_i.a_load) begin
      cur_q  <= cur_upd;
      sh_q   <= sh_upd;
      cand_q <= sh_upd;
      if (ctl_i.close) begin
        prev_q <= cur_upd;
      end
    end
  end

  // minimum stage
  assign cand_lt    = ctl_i.b_cand && (cand_q < {1'b0, min_q});
  assign min_next_o = cand_lt ? cand_q[SigW-1:0] : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinStart;
    end else if (ctl_i.b_adv) begin
      min_q <= ctl_i.b_row_end ? MinStart : min_next_o;
    end
  end

endmodule

// File: src/shingle_minhash_signature.sv
`timescale 1ns / 1ps
// top level of the shingle minhash signature block
// depends on smh_pkg and smh_lane

// Takes one character (or a bare mark) per cycle and can accept a new
// transaction every cycle while input stall is low. Each lane advances its token
// and shingle hashes in the accepting cycle (two 32x32 multiplies and one 32x8
// multiply per hash, side by side, so the path is one multiply and an xor), then
// folds a closed shingle into the running minimum in the minimum stage. The
// signatures pass from the minimum stage into the output register, which raises
// the output transaction. Input stall rises only when a finished result is held
// by output stall and another row end waits behind it. Configuration registers
// are read at accept time and should be written while the block is idle.

module shingle_minhash_signature
  import smh_pkg::*;
#(
  parameter int unsigned NumHashes = MaxHashes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SymW-1:0]      symbol_i,
  input  logic                 symbol_valid_i,
  input  logic                 token_end_i,
  input  logic                 row_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SigW-1:0]      signature_zero_o,
  output logic [SigW-1:0]      signature_one_o,
  output logic [SigW-1:0]      signature_two_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [HashW-1:0]     cfg_data_i
);

  logic [HashW-1:0] seed_q [MaxHashes];
  logic [HashW-1:0] mult_q [MaxHashes];
  logic [HashW-1:0] chain_q;

  logic [1:0]       tokens_seen_q, tokens_seen_d;
  logic             token_started_q, token_started_d;
  logic             b_vld_q, b_vld_d, b_cand_q, b_rend_q;
  logic             out_valid_q, out_valid_d;
  logic [SigW-1:0]  sig_q [MaxHashes];
  logic [SigW-1:0]  lane_min [MaxHashes];

  logic             in_fire, started_new, close, b_stall, b_adv, out_load, cand_new;
  ctl_t             ctl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q[0] <= SeedZeroRst;
      seed_q[1] <= SeedOneRst;
      seed_q[2] <= SeedTwoRst;
      chain_q   <= ChainMultRst;
      mult_q[0] <= MultZeroRst;
      mult_q[1] <= MultOneRst;
      mult_q[2] <= MultTwoRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSeedZero:  seed_q[0] <= cfg_data_i;
        CfgSeedOne:   seed_q[1] <= cfg_data_i;
        CfgSeedTwo:   seed_q[2] <= cfg_data_i;
        CfgChainMult: chain_q   <= cfg_data_i;
        CfgMultZero:  mult_q[0] <= cfg_data_i;
        CfgMultOne:   mult_q[1] <= cfg_data_i;
        CfgMultTwo:   mult_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // row control
  assign b_stall     = b_vld_q && b_rend_q && out_valid_q && out_stall_i;
  assign in_stall_o  = b_stall;
  assign b_adv       = b_vld_q && !b_stall;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign started_new = symbol_valid_i || token_started_q;
  assign close       = (token_end_i || row_end_i) && started_new;
  assign cand_new    = close && (tokens_seen_q != 2'd0);

  always_comb begin
    tokens_seen_d   = tokens_seen_q;
    token_started_d = token_started_q;
    if (in_fire) begin
      if (row_end_i) begin
        tokens_seen_d   = 2'd0;
        token_started_d = 1'b0;
      end else begin
        token_started_d = started_new && !close;
        if (close && tokens_seen_q != 2'd2) begin
          tokens_seen_d = tokens_seen_q + 2'd1;
        end
      end
    end
  end

  always_comb begin
    b_vld_d = b_vld_q;
    if (in_fire) begin
      b_vld_d = cand_new || row_end_i;
    end else if (b_adv) begin
      b_vld_d = 1'b0;
    end
  end

  assign out_load    = b_adv && b_rend_q;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokens_seen_q   <= 2'd0;
      token_started_q <= 1'b0;
      b_vld_q         <= 1'b0;
      b_cand_q        <= 1'b0;
      b_rend_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      tokens_seen_q   <= tokens_seen_d;
      token_started_q <= token_started_d;
      b_vld_q         <= b_vld_d;
      out_valid_q     <= out_valid_d;
      if (in_fire) begin
        b_cand_q <= cand_new;
        b_rend_q <= row_end_i;
      end
    end
  end

  assign ctl = '{
    a_load:    in_fire,
    sym_vld:   symbol_valid_i,
    started:   token_started_q,
    close:     close,
    b_adv:     b_adv,
    b_cand:    b_cand_q,
    b_row_end: b_rend_q
  };

  for (genvar k = 0; k < MaxHashes; k++) begin : g_lane
    if (k < NumHashes) begin : g_used
      smh_lane u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .symbol_i   (symbol_i),
        .seed_i     (seed_q[k]),
        .chain_i    (chain_q),
        .mult_i     (mult_q[k]),
        .min_next_o (lane_min[k])
      );
    end else begin : g_unused
      assign lane_min[k] = '0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sig_q <= lane_min;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign signature_zero_o = sig_q[0];
  assign signature_one_o  = sig_q[1];
  assign signature_two_o  = sig_q[2];

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && b_rend_q))
    else $error("input stall without a held result");

  a_rend_to_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && row_end_i) |=> (b_vld_q && b_rend_q))
    else $error("row end did not reach the minimum stage");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && row_end_i) |=> (tokens_seen_q == 2'd0 && !token_started_q))
    else $error("row state not cleared after row end");

  a_cand_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_cand_q && b_vld_q |-> $past(tokens_seen_q) != 2'd0 || !$past(in_fire))
    else $error("shingle candidate taken before a second token");

endmodule
